/* rtl/snd_pkg.sv */
`default_nettype none
package snd_pkg;

    localparam int WINDOW_BYTES = 65536;
    localparam int AW = $clog2(WINDOW_BYTES);
    localparam int HW = $clog2(WINDOW_BYTES + 1);

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_LIT  = 2'd1;
    localparam logic [1:0] CMD_COPY = 2'd2;

    typedef struct packed {
        logic        restart;
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [31:0] offset;
        logic [6:0]  len;
    } t_cmd;

endpackage
`default_nettype wire

/* rtl/snd_ram.sv */
`default_nettype none
module snd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/snd_front.sv */
`default_nettype none
module snd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_stream_start,
    input  wire logic [7:0]    i_in_byte,
    output logic               o_cmd_push,
    output snd_pkg::t_cmd      o_cmd
);
    import snd_pkg::*;

    localparam logic [1:0] PH_TAG     = 2'd0;
    localparam logic [1:0] PH_LITLEN  = 2'd1;
    localparam logic [1:0] PH_LITDATA = 2'd2;
    localparam logic [1:0] PH_COPYOFF = 2'd3;

    logic [1:0]  r_phase, n_phase;
    logic [2:0]  r_extra, n_extra;
    logic [1:0]  r_taken, n_taken;
    logic [32:0] r_lit, n_lit;
    logic [6:0]  r_clen, n_clen;
    logic [31:0] r_acc, n_acc;

    always_comb begin
        logic [31:0] sh;
        sh = 32'(i_in_byte) << {r_taken, 3'b000};
        n_phase = r_phase;
        n_extra = r_extra;
        n_taken = r_taken;
        n_lit   = r_lit;
        n_clen  = r_clen;
        n_acc   = r_acc;
        o_cmd_push    = 1'b0;
        o_cmd.restart = 1'b0;
        o_cmd.kind    = CMD_NONE;
        o_cmd.data    = i_in_byte;
        o_cmd.offset  = r_acc;
        o_cmd.len     = r_clen;
        if (i_accept) begin
            if (i_stream_start) begin
                n_phase = PH_TAG;
                n_lit   = '0;
                o_cmd_push    = 1'b1;
                o_cmd.restart = 1'b1;
            end
            case (i_stream_start ? PH_TAG : r_phase)
                PH_TAG: begin
                    n_taken = '0;
                    n_acc   = '0;
                    if (i_in_byte[1:0] == 2'd0) begin
                        if (i_in_byte[7:2] >= 6'd60) begin
                            n_extra = 3'(i_in_byte[7:2] - 6'd59);
                            n_phase = PH_LITLEN;
                        end else begin
                            n_lit   = 33'(i_in_byte[7:2]) + 33'd1;
                            n_phase = PH_LITDATA;
                        end
                    end else if (i_in_byte[1:0] == 2'd1) begin
                        n_clen  = 7'(i_in_byte[4:2]) + 7'd4;
                        n_acc   = {21'b0, i_in_byte[7:5], 8'b0};
                        n_extra = 3'd1;
                        n_phase = PH_COPYOFF;
                    end else begin
                        n_clen  = 7'(i_in_byte[7:2]) + 7'd1;
                        n_extra = (i_in_byte[1:0] == 2'd2) ? 3'd2 : 3'd4;
                        n_phase = PH_COPYOFF;
                    end
                end
                PH_LITLEN: begin
                    n_taken = r_taken + 2'd1;
                    n_extra = r_extra - 3'd1;
                    if (r_extra == 3'd1) begin
                        n_lit   = 33'(r_acc | sh) + 33'd1;
                        n_acc   = '0;
                        n_phase = PH_LITDATA;
                    end else begin
                        n_acc = r_acc | sh;
                    end
                end
                PH_LITDATA: begin
                    o_cmd_push = 1'b1;
                    o_cmd.kind = CMD_LIT;
                    if (r_lit != '0) begin
                        n_lit = r_lit - 33'd1;
                    end
                    if (r_lit <= 33'd1) begin
                        n_phase = PH_TAG;
                    end
                end
                default: begin
                    // offset bytes never overlap, so or-ing equals adding
                    n_acc   = r_acc | sh;
                    n_taken = r_taken + 2'd1;
                    n_extra = r_extra - 3'd1;
                    if (r_extra == 3'd1) begin
                        o_cmd_push   = 1'b1;
                        o_cmd.kind   = CMD_COPY;
                        o_cmd.offset = r_acc | sh;
                        n_phase      = PH_TAG;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_extra <= '0;
            r_taken <= '0;
            r_lit   <= '0;
            r_clen  <= '0;
            r_acc   <= '0;
        end else begin
            r_phase <= n_phase;
            r_extra <= n_extra;
            r_taken <= n_taken;
            r_lit   <= n_lit;
            r_clen  <= n_clen;
            r_acc   <= n_acc;
        end
    end
endmodule
`default_nettype wire

/* rtl/snd_cmdq.sv */
`default_nettype none
module snd_cmdq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  snd_pkg::t_cmd      i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output snd_pkg::t_cmd      o_cmd
);
    import snd_pkg::*;

    t_cmd       r_ent [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_ent[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

/* rtl/snd_back.sv */
`default_nettype none
module snd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  snd_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic [7:0]         o_out_byte,
    output logic               o_last_of_run,
    output logic               o_bad_offset
);
    import snd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DATA = 2'd2;

    logic [1:0]    r_st, n_st;
    logic [AW-1:0] r_wp, n_wp;
    logic [HW-1:0] r_held, n_held;
    logic [HW-1:0] r_off, n_off;
    logic [6:0]    r_cnt, n_cnt;
    logic          r_ovld, n_ovld;
    logic [7:0]    r_obyte, n_obyte;
    logic          r_olast, n_olast;
    logic          r_obad, n_obad;

    logic          room, we;
    logic [7:0]    wdata, rdata;
    logic [AW-1:0] raddr;
    logic [HW-1:0] wp_ext, src;

    assign room   = !r_ovld || i_pop;
    assign wp_ext = HW'(r_wp);
    assign src    = (wp_ext >= r_off) ? wp_ext - r_off
                                      : wp_ext + HW'(WINDOW_BYTES) - r_off;
    assign raddr  = AW'(src);

    snd_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wp),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_st    = r_st;
        n_wp    = r_wp;
        n_held  = r_held;
        n_off   = r_off;
        n_cnt   = r_cnt;
        n_ovld  = r_ovld && !i_pop;
        n_obyte = r_obyte;
        n_olast = r_olast;
        n_obad  = r_obad;
        o_cmd_pop = 1'b0;
        we    = 1'b0;
        wdata = i_cmd.data;
        case (r_st)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.restart) begin
                        n_wp   = '0;
                        n_held = '0;
                        o_cmd_pop = 1'b1;
                    end else if (i_cmd.kind == CMD_LIT) begin
                        if (room) begin
                            we      = 1'b1;
                            n_ovld  = 1'b1;
                            n_obyte = i_cmd.data;
                            n_olast = 1'b1;
                            n_obad  = 1'b0;
                            o_cmd_pop = 1'b1;
                        end
                    end else if (i_cmd.kind == CMD_COPY) begin
                        if (i_cmd.offset == '0 || i_cmd.offset > 32'(r_held)) begin
                            if (room) begin
                                n_ovld  = 1'b1;
                                n_obyte = '0;
                                n_olast = 1'b1;
                                n_obad  = 1'b1;
                                o_cmd_pop = 1'b1;
                            end
                        end else begin
                            n_off = HW'(i_cmd.offset);
                            n_cnt = i_cmd.len;
                            n_st  = ST_READ;
                            o_cmd_pop = 1'b1;
                        end
                    end else begin
                        o_cmd_pop = 1'b1;
                    end
                end
            end
            ST_READ: begin
                n_st = ST_DATA;
            end
            ST_DATA: begin
                if (room) begin
                    we      = 1'b1;
                    wdata   = rdata;
                    n_ovld  = 1'b1;
                    n_obyte = rdata;
                    n_olast = (r_cnt == 7'd1);
                    n_obad  = 1'b0;
                    n_cnt   = r_cnt - 7'd1;
                    n_st    = (r_cnt == 7'd1) ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
        if (we) begin
            n_wp = (r_wp == AW'(WINDOW_BYTES - 1)) ? '0 : r_wp + AW'(1);
            if (r_held != HW'(WINDOW_BYTES)) begin
                n_held = r_held + HW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_off   <= n_off;
        r_cnt   <= n_cnt;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        r_obad  <= n_obad;
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_wp   <= '0;
            r_held <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_wp   <= n_wp;
            r_held <= n_held;
            r_ovld <= n_ovld;
        end
    end

    assign o_empty       = !r_ovld;
    assign o_out_byte    = r_obyte;
    assign o_last_of_run = r_olast;
    assign o_bad_offset  = r_obad;
endmodule
`default_nettype wire

/* rtl/snappy_stream_decoder.sv */
// Byte-stream decompressor for the snappy format, without length preamble.
// Input channel: drive stream_start and in_byte with push; a request is
// taken on a clock edge where push is high and full is low. Set
// stream_start on the first byte of every stream; it clears the parser and
// the history count.
// Result channel: while empty is low, out_byte, last_of_run and bad_offset
// show the oldest result; pop takes it. last_of_run marks the final result
// of the input byte that caused it. A bad copy offset yields one result
// with bad_offset set and out_byte zero.
// Timing: while full is low, the parser takes one byte a cycle into a
// two-entry command queue. A literal byte is registered into the output
// register once the back end is idle and has room; copy bytes are handled
// one at a time, each a registered read of the 64 KiB history RAM followed
// by its write-back. full rises while a copy runs and the queue fills.
// Reset (synchronous, active low) empties queue and output register; the
// history RAM needs no clearing. If pop stays low, the result register
// holds, the back end stops, and the queue then backs up into full.
`default_nettype none
module snappy_stream_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic       i_stream_start,
    input  wire logic [7:0] i_in_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run,
    output logic            o_bad_offset
);
    import snd_pkg::*;

    logic accept, f_push, q_valid, q_pop;
    t_cmd f_cmd, q_cmd;

    assign accept = push && !full;

    snd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_stream_start (i_stream_start),
        .i_in_byte      (i_in_byte),
        .o_cmd_push     (f_push),
        .o_cmd          (f_cmd)
    );

    snd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    snd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_cmd),
        .o_cmd_pop     (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_bad_offset  (o_bad_offset)
    );
endmodule
`default_nettype wire

/* rtl/snd_checker.sv */
`default_nettype none
module snd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_last_of_run,
    input wire logic       o_bad_offset
);
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("not idle after reset");

    a_bad_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_bad_offset) |-> (o_out_byte == 8'd0 && o_last_of_run))
        else $error("error result malformed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte)
                              && $stable(o_last_of_run) && $stable(o_bad_offset)))
        else $error("stalled result changed");
endmodule

bind snappy_stream_decoder snd_checker u_snd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_out_byte    (o_out_byte),
    .o_last_of_run (o_last_of_run),
    .o_bad_offset  (o_bad_offset)
);
`default_nettype wire
